// ===== src/arp_pkg.sv =====
// Package for the ARM32 relocation patcher: relocation type codes, status codes,
// and the item structs passed between the top level and the patch datapath.
// No dependencies.
package arp_pkg;

   // ELF ARM relocation type numbers handled by the patcher
   localparam logic [7:0] RT_PC24   = 8'd1;
   localparam logic [7:0] RT_ABS32  = 8'd2;
   localparam logic [7:0] RT_CALL   = 8'd28;
   localparam logic [7:0] RT_JUMP24 = 8'd29;
   localparam logic [7:0] RT_V4BX   = 8'd40;
   localparam logic [7:0] RT_PREL31 = 8'd42;
   localparam logic [7:0] RT_MOVW   = 8'd43;
   localparam logic [7:0] RT_MOVT   = 8'd44;

   localparam logic CMD_UNLINK = 1'b0;
   localparam logic CMD_RELINK = 1'b1;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_UNLINK = 2'd1,
      ST_BAD_RELINK = 2'd2,
      ST_RANGE      = 2'd3
   } arp_status_type;

   localparam int REQ_DATA_W = 96;
   localparam int REQ_USER_W = 9;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   typedef struct packed {
      logic        cmd;
      logic [31:0] target_word;
      logic [31:0] place_address;
      logic [7:0]  reloc_type;
      logic [31:0] symbol_value;
   } arp_item_type;

   typedef struct packed {
      logic [31:0]    patched_word;
      arp_status_type status;
   } arp_result_type;

endpackage

// ===== src/arm32_relocation_patcher.sv =====
// Channel  | Dir | Ports            | Contents
// ---------+-----+------------------+-----------------------------------------------
// request  | in  | req_t{valid,ready,data,user} | data: word, place, symbol; user: cmd, type
// response | out | rsp_t{valid,ready,data,user} | data: patched word; user: status
//
// Top level of the ARM32 relocation patcher: input register, patch datapath,
// result register. Depends on arp_pkg and arp_patch.
//
// One item per cycle sustained while rsp is not stalled; an item enters the input register
// when it is accepted, moves on to the result register and shows on rsp from there until
// it is taken.
// Reset is synchronous and clears only the two valid flags.
// A stalled response holds its result; the input register keeps accepting while
// it is empty or the result register can move.
module arm32_relocation_patcher
   import arp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] target_word, [63:32] place_address, [95:64] symbol_value
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] cmd, [8:1] reloc_type
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] patched_word
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic           in_valid_ff;
   arp_item_type   in_item_ff;
   arp_item_type   in_item_in;
   logic           out_valid_ff;
   arp_result_type out_result_ff;
   arp_result_type patch_result;
   logic           out_ready;
   logic           in_ready;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign in_ready   = !in_valid_ff || out_ready;
   assign req_tready = in_ready;

   always_comb begin
      in_item_in.cmd           = req_tuser[0];
      in_item_in.reloc_type    = req_tuser[8:1];
      in_item_in.target_word   = req_tdata[31:0];
      in_item_in.place_address = req_tdata[63:32];
      in_item_in.symbol_value  = req_tdata[95:64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
   end

   arp_patch u_patch (
      .item   (in_item_ff),
      .result (patch_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && in_valid_ff) begin
         out_result_ff <= patch_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_result_ff.patched_word;
   assign rsp_tuser  = out_result_ff.status;

endmodule

// ===== src/arp_patch.sv =====
// Patch datapath: one relocation applied to or removed from one 32-bit word.
// Purely combinational; sits between the input and result registers.
// Depends on arp_pkg.
module arp_patch
   import arp_pkg::*;
(
   input  arp_item_type   item,
   output arp_result_type result
);

   localparam logic [31:0] BRANCH_BIAS = 32'd8;

   logic [31:0] w;
   logic [31:0] p;
   logic [31:0] s;
   logic [7:0]  t;
   logic [31:0] br_addend;
   logic [31:0] pc8;
   logic [31:0] br_unlink;
   logic [31:0] br_relink;
   logic        br_in_range;
   logic [31:0] br_unlink_word;
   logic [31:0] br_relink_word;
   logic [15:0] imm;
   logic [15:0] s_half;
   logic [15:0] imm_new;
   logic [31:0] imm_word;
   logic [31:0] prel;

   always_comb begin
      w = item.target_word;
      p = item.place_address;
      s = item.symbol_value;
      t = item.reloc_type;

      // 24-bit word offset, sign-extended to a byte offset
      br_addend = {{6{w[23]}}, w[23:0], 2'b00};
      pc8       = p + BRANCH_BIAS;
      br_unlink = br_addend - s + pc8;
      br_relink = s + br_addend - pc8;
      // in range when |offset| < 2^26, i.e. -2^26 < offset < 2^26
      br_in_range = br_relink[31] ? ((&br_relink[31:26]) && (|br_relink[25:0]))
                                  : ~(|br_relink[31:26]);
      br_unlink_word = {w[31:24], br_unlink[25:2]};
      br_relink_word = {w[31:24], br_relink[25:2]};

      // MOVW/MOVT immediate is imm4:imm12, arithmetic wraps at 16 bits
      imm      = {w[19:16], w[11:0]};
      s_half   = (t == RT_MOVT) ? s[31:16] : s[15:0];
      imm_new  = (item.cmd == CMD_RELINK) ? (imm + s_half) : (imm - s_half);
      imm_word = {w[31:20], imm_new[15:12], w[15:12], imm_new[11:0]};

      prel = w + s - p;

      result.patched_word = w;
      result.status       = ST_OK;
      unique case (t) inside
         RT_PC24, RT_CALL, RT_JUMP24: begin
            if (item.cmd == CMD_RELINK) begin
               if (br_in_range) begin
                  result.patched_word = br_relink_word;
               end else begin
                  result.status = ST_RANGE;
               end
            end else begin
               result.patched_word = br_unlink_word;
            end
         end
         RT_ABS32: begin
            result.patched_word = (item.cmd == CMD_RELINK) ? (w + s) : (w - s);
         end
         RT_MOVW, RT_MOVT: begin
            result.patched_word = imm_word;
         end
         RT_V4BX: begin
            result.patched_word = w;
         end
         RT_PREL31: begin
            if (item.cmd == CMD_RELINK) begin
               result.patched_word = {1'b0, prel[30:0]};
            end
         end
         default: begin
            result.status = (item.cmd == CMD_RELINK) ? ST_BAD_RELINK : ST_BAD_UNLINK;
         end
      endcase
   end

endmodule

// ===== src/arp_checker.sv =====
// Port-level checker for the ARM32 relocation patcher, bound to the top level.
// Depends on arp_pkg.
module arp_checker
   import arp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // input backpressure only comes from a full, stalled result register
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |-> (rsp_tvalid && !rsp_tready))
      else $error("request stalled without a stalled response");

   // an empty result register never blocks the input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request not ready while result register is empty");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind arm32_relocation_patcher arp_checker u_arp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/arm32_relocation_patcher_tb.sv =====
// Self-checking bench for arm32_relocation_patcher: a directed table of relocations, then
// random relink/unlink items under three idle patterns, each result checked against a
// fixed table value or the built-in patch predictor. Depends on arp_pkg and the patcher RTL.
module arm32_relocation_patcher_tb
   import arp_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DIRECTED_COUNT = 24;
   localparam int RANDOM_PER_PHASE[3] = '{300, 300, 250};

   // types outside the supported set
   localparam logic [7:0] RT_NONE  = 8'd0;
   localparam logic [7:0] RT_REL32 = 8'd3;
   localparam logic [7:0] RT_TOP   = 8'd255;

   typedef struct packed {
      arp_item_type   item;
      logic           typed;
      arp_result_type want;
   } reloc_case_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [31:0] target_word, [63:32] place_address, [95:64] symbol_value
   logic [REQ_DATA_W-1:0] req_tdata;
   // [0] cmd, [8:1] reloc_type
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [31:0] patched_word
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [1:0] status
   logic [RSP_USER_W-1:0] rsp_tuser;

   arp_result_type expected_patches[$];
   int  fail_count;
   int  results_checked;
   int  range_count;
   int  unknown_count;
   int  cycle_count;
   int  req_idle_pct;
   int  rsp_idle_pct;
   bit  hold_off_request;

   reloc_case_type directed_cases [DIRECTED_COUNT] = '{
      // after reset: unknown types report the mode and return the word; then V4BX, PREL31, ABS32
      '{'{CMD_UNLINK, 32'hFFFF_FFFF, 32'h0000_0000, RT_NONE, 32'h0000_0000},
        1'b1, '{32'hFFFF_FFFF, ST_BAD_UNLINK}},
      '{'{CMD_RELINK, 32'h0000_0000, 32'hFFFF_FFFF, RT_TOP, 32'hFFFF_FFFF},
        1'b1, '{32'h0000_0000, ST_BAD_RELINK}},
      '{'{CMD_UNLINK, 32'hA5A5_A5A5, 32'h1234_5678, RT_REL32, 32'h8765_4321},
        1'b1, '{32'hA5A5_A5A5, ST_BAD_UNLINK}},
      '{'{CMD_UNLINK, 32'hE12F_FF10, 32'hFFFF_FFFF, RT_V4BX, 32'hFFFF_FFFF},
        1'b1, '{32'hE12F_FF10, ST_OK}},
      '{'{CMD_RELINK, 32'hFFFF_FFFF, 32'h0000_0000, RT_V4BX, 32'hFFFF_FFFF},
        1'b1, '{32'hFFFF_FFFF, ST_OK}},
      '{'{CMD_UNLINK, 32'hDEAD_BEEF, 32'h0000_1000, RT_PREL31, 32'h1234_5678},
        1'b1, '{32'hDEAD_BEEF, ST_OK}},
      '{'{CMD_RELINK, 32'hFFFF_FFFF, 32'h0000_0000, RT_ABS32, 32'h0000_0001},
        1'b1, '{32'h0000_0000, ST_OK}},
      '{'{CMD_UNLINK, 32'h0000_0000, 32'h0000_0000, RT_ABS32, 32'h0000_0000},
        1'b1, '{32'h0000_0000, ST_OK}},
      '{'{CMD_RELINK, 32'h0000_0000, 32'h0000_0000, RT_PREL31, 32'hFFFF_FFFF},
        1'b1, '{32'h7FFF_FFFF, ST_OK}},
      // branch offsets just past the reach, both signs, and the most negative value; later rows use the predictor
      '{'{CMD_RELINK, 32'hEB00_0000, 32'h0000_0000, RT_CALL, 32'h0400_0008},
        1'b1, '{32'hEB00_0000, ST_RANGE}},
      '{'{CMD_RELINK, 32'hEA00_0000, 32'h03FF_FFF8, RT_JUMP24, 32'h0000_0000},
        1'b1, '{32'hEA00_0000, ST_RANGE}},
      '{'{CMD_RELINK, 32'h0A00_0000, 32'h0000_0000, RT_PC24, 32'h8000_0008},
        1'b1, '{32'h0A00_0000, ST_RANGE}},
      '{'{CMD_RELINK, 32'hEB00_0000, 32'h0000_8000, RT_PC24, 32'h0000_9000},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_RELINK, 32'hEB00_0000, 32'h03FF_FFF4, RT_PC24, 32'h0000_0000},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_RELINK, 32'h00FF_FFFF, 32'hFFFF_FFF8, RT_JUMP24, 32'hFFFF_FFFF},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_UNLINK, 32'hEAFF_FFFE, 32'h0000_8000, RT_PC24, 32'h0000_0100},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_UNLINK, 32'h0080_0000, 32'hFFFF_FFFF, RT_CALL, 32'h0000_0000},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_UNLINK, 32'hFF7F_FFFF, 32'h0000_0000, RT_JUMP24, 32'hFFFF_FFFF},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_UNLINK, 32'hE30F_0FFF, 32'h0000_0000, RT_MOVW, 32'h0000_FFFF},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_RELINK, 32'hE340_0000, 32'h0000_0000, RT_MOVW, 32'hFFFF_FFFF},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_UNLINK, 32'hE340_0000, 32'h0000_0000, RT_MOVT, 32'h0001_0000},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_RELINK, 32'hE34F_0FFF, 32'h0000_0000, RT_MOVT, 32'hFFFF_0000},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_RELINK, 32'h8000_0000, 32'h1234_5678, RT_PREL31, 32'h0000_1000},
        1'b0, '{32'h0, ST_OK}},
      '{'{CMD_UNLINK, 32'h0000_0000, 32'h0000_0000, RT_ABS32, 32'hFFFF_FFFF},
        1'b0, '{32'h0, ST_OK}}
   };

   arm32_relocation_patcher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic arp_result_type predict_patch(arp_item_type it);
      arp_result_type res;
      logic [31:0]    w;
      logic [31:0]    branch_addend;
      logic [31:0]    offset;
      logic [31:0]    magnitude;
      logic [31:0]    prel_sum;
      logic [15:0]    imm;
      logic [15:0]    new_imm;
      logic           relink;
      w = it.target_word;
      relink = (it.cmd == CMD_RELINK);
      res.patched_word = w;
      res.status = ST_OK;
      branch_addend = {{6{w[23]}}, w[23:0], 2'b00};
      imm = {w[19:16], w[11:0]};
      case (it.reloc_type)
         RT_PC24, RT_CALL, RT_JUMP24: begin
            if (relink) begin
               offset = it.symbol_value + branch_addend - (it.place_address + 32'd8);
               magnitude = offset[31] ? -offset : offset;
               if (magnitude[31:26] != 6'd0)
                  res.status = ST_RANGE;
               else
                  res.patched_word = {w[31:24], offset[25:2]};
            end else begin
               offset = branch_addend - (it.symbol_value - (it.place_address + 32'd8));
               res.patched_word = {w[31:24], offset[25:2]};
            end
         end
         RT_ABS32: begin
            res.patched_word = relink ? w + it.symbol_value : w - it.symbol_value;
         end
         RT_MOVW, RT_MOVT: begin
            // MOVT carries the upper half of the symbol; imm16 wraps
            if (it.reloc_type == RT_MOVW)
               new_imm = relink ? imm + it.symbol_value[15:0] : imm - it.symbol_value[15:0];
            else
               new_imm = relink ? imm + it.symbol_value[31:16]
                                : imm - it.symbol_value[31:16];
            res.patched_word = {w[31:20], new_imm[15:12], w[15:12], new_imm[11:0]};
         end
         RT_V4BX: begin
            res.patched_word = w;
         end
         RT_PREL31: begin
            prel_sum = w + it.symbol_value - it.place_address;
            if (relink)
               res.patched_word = {1'b0, prel_sum[30:0]};
         end
         default: begin
            res.status = relink ? ST_BAD_RELINK : ST_BAD_UNLINK;
         end
      endcase
      return res;
   endfunction

   function automatic arp_item_type random_relocation();
      arp_item_type it;
      it.cmd = 1'($urandom_range(0, 1));
      it.target_word = $urandom;
      it.place_address = $urandom;
      it.symbol_value = $urandom;
      case ($urandom_range(0, 19))
         0, 1, 2: it.reloc_type = RT_PC24;
         3, 4:    it.reloc_type = RT_CALL;
         5, 6:    it.reloc_type = RT_JUMP24;
         7, 8:    it.reloc_type = RT_ABS32;
         9, 10:   it.reloc_type = RT_MOVW;
         11, 12:  it.reloc_type = RT_MOVT;
         13:      it.reloc_type = RT_V4BX;
         14, 15:  it.reloc_type = RT_PREL31;
         default: it.reloc_type = 8'($urandom_range(0, 255));
      endcase
      // keep most branch targets near the site so relinks land around the reach limit
      if ((it.reloc_type == RT_PC24 || it.reloc_type == RT_CALL ||
           it.reloc_type == RT_JUMP24) && $urandom_range(0, 9) < 7)
         it.symbol_value = it.place_address + $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
      return it;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_relocation(input arp_item_type it, input arp_result_type want);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {it.symbol_value, it.place_address, it.target_word};
      req_tuser <= {it.reloc_type, it.cmd};
      do @(posedge clock); while (!req_tready);
      expected_patches.push_back(want);
      @(negedge clock);
   endtask

   // receiver: random backpressure, plus one long hold-off on request
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      arp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_patches.size() == 0) begin
            $error("unexpected result: patched_word %h status %0d", rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = expected_patches.pop_front();
            results_checked++;
            if (rsp_tdata != want.patched_word) begin
               $error("patched_word: expected %h, actual %h", want.patched_word, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser != want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               fail_count++;
            end
            if (want.status == ST_RANGE)
               range_count++;
            else if (want.status != ST_OK)
               unknown_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_patches.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      arp_item_type it;
      arp_result_type want;
      int random_sent;
      fail_count = 0;
      results_checked = 0;
      range_count = 0;
      unknown_count = 0;
      random_sent = 0;
      hold_off_request = 1'b0;
      req_idle_pct = 37;
      rsp_idle_pct = 51;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_cases[i]) begin
         it = directed_cases[i].item;
         want = directed_cases[i].typed ? directed_cases[i].want : predict_patch(it);
         send_relocation(it, want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_idle_pct = 37; rsp_idle_pct = 51; end
            1: begin
               req_idle_pct = 51;
               rsp_idle_pct = 37;
               // stall the output long enough to back the pipe up into req_tready
               hold_off_request = 1'b1;
            end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE[phase]; n++) begin
            it = random_relocation();
            send_relocation(it, predict_patch(it));
            random_sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (expected_patches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d table rows and %0d random relocations, %0d results checked",
               DIRECTED_COUNT, random_sent, results_checked);
      $display("of those %0d branch reach failures and %0d unknown types, %0d mismatches",
               range_count, unknown_count, fail_count);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
